// ===== rtl/arcvg_pkg.sv =====
// Shared types, constants, sine table builder and microprogram for the arc vertex generator.
`default_nettype none

package arcvg_pkg;

  // Input and output field widths.
  localparam int COORD_W = 16;
  localparam int RADIUS_W = 15;
  localparam int SPAN_W = 15;
  localparam int SEG_W = 7;
  localparam int INDEX_W = 6;

  // Angle format: 13 bits cover one full turn, 11 bits one quarter turn.
  localparam int ANGLE_W = 13;
  localparam int QUARTER_W = 11;
  localparam logic [QUARTER_W:0] QUARTER_TURN = 12'd2048;

  // Sine table entries are unsigned Q0.15 magnitudes, at most 32767.
  localparam int TRIG_W = 15;

  // The span magnitude divider retires one quotient bit per step.
  localparam int DIV_STEPS = SPAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // pi/2 in Q2.30 and the Taylor series denominators (2n)(2n+1).
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Sine of a Q2.30 angle, rounded to Q0.15 and clamped to 32767.
  function automatic logic [TRIG_W-1:0] sine_entry(input longint unsigned x);
    longint unsigned term;
    longint sum;
    longint q;
    int n;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[TRIG_W-1:0];
  endfunction

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_LOOKUP,
    OP_MUL,
    OP_EMIT
  } op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_COUNT_ZERO,
    JC_DIV_MORE,
    JC_MORE_VERTS
  } cond_t;

  localparam int PROG_LEN = 6;
  localparam int STEP_W = $clog2(PROG_LEN);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD = 3'd0;
  localparam step_t STEP_DIV = 3'd1;
  localparam step_t STEP_LOOKUP = 3'd2;
  localparam step_t STEP_MUL = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;
  localparam step_t STEP_DONE = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // The program: load a request, divide, then three steps per vertex and a closing step.
  localparam ucode_t PROGRAM [PROG_LEN] = '{
    '{op: OP_LOAD,   cond: JC_COUNT_ZERO, target: STEP_LOAD},
    '{op: OP_DIV,    cond: JC_DIV_MORE,   target: STEP_DIV},
    '{op: OP_LOOKUP, cond: JC_NEXT,       target: STEP_LOAD},
    '{op: OP_MUL,    cond: JC_NEXT,       target: STEP_LOAD},
    '{op: OP_EMIT,   cond: JC_MORE_VERTS, target: STEP_LOOKUP},
    '{op: OP_NOP,    cond: JC_ALWAYS,     target: STEP_LOAD}
  };

  // Flags from the datapath that the sequencer tests.
  typedef struct packed {
    logic in_valid;
    logic count_zero;
    logic div_more;
    logic last_vertex;
    logic out_free;
  } seq_status_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic fire;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/arcvg_if.sv =====
// Handshake interfaces for arc requests and generated vertices.
`default_nettype none

interface arcvg_req_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  center_x;
  logic signed [15:0]  center_y;
  logic        [14:0]  radius;
  logic signed [14:0]  span;
  logic        [6:0]   segment_count;

  modport source(output valid, center_x, center_y, radius, span, segment_count, input ready);
  modport sink(input valid, center_x, center_y, radius, span, segment_count, output ready);
endinterface

interface arcvg_vtx_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  vertex_x;
  logic signed [15:0]  vertex_y;
  logic        [5:0]   vertex_index;
  logic                last;

  modport source(output valid, vertex_x, vertex_y, vertex_index, last, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_index, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/arcvg_sine_rom.sv =====
// Quarter-wave sine table with two registered read ports.
`default_nettype none

module arcvg_sine_rom
  import arcvg_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic [$clog2(DEPTH+1)-1:0]       addr_sin,
  input  wire logic [$clog2(DEPTH+1)-1:0]       addr_cos,
  output      logic [TRIG_W-1:0]                data_sin,
  output      logic [TRIG_W-1:0]                data_cos
);

  logic [TRIG_W-1:0] rom [DEPTH+1];

  // Each entry is fixed at elaboration from the series expansion.
  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam longint unsigned Angle = (HALF_PI_Q30 * 64'(k)) / DEPTH;
    assign rom[k] = sine_entry(Angle);
  end

  always_ff @(posedge clk) begin
    data_sin <= rom[addr_sin];
    data_cos <= rom[addr_cos];
  end

endmodule

`default_nettype wire

// ===== rtl/arcvg_sequencer.sv =====
// Microprogram sequencer: step counter, control word fetch and conditional jumps.
`default_nettype none

module arcvg_sequencer
  import arcvg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire seq_status_t status,
  output      seq_ctrl_t   ctrl
);

  step_t  pc;
  step_t  pc_next;
  ucode_t word;
  logic   stall;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = PROGRAM[pc];
    // The load step waits for a request, the emit step for a free output.
    stall = ((word.op == OP_LOAD) && !status.in_valid) ||
            ((word.op == OP_EMIT) && !status.out_free);
    unique case (word.cond)
      JC_NEXT:       take = 1'b0;
      JC_ALWAYS:     take = 1'b1;
      JC_COUNT_ZERO: take = status.count_zero;
      JC_DIV_MORE:   take = status.div_more;
      JC_MORE_VERTS: take = !status.last_vertex;
      default:       take = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
    ctrl.op = word.op;
    ctrl.fire = !stall;
  end

endmodule

`default_nettype wire

// ===== rtl/arc_vertex_generator.sv =====
// Top level of the arc vertex generator: datapath, sequencer and sine table.
`default_nettype none

// Takes one arc request per beat on req and emits segment_count vertices on vtx, one beat
// each, at the angles span*i/segment_count (truncated toward zero) for i from 0 up, in units
// of 1/4096 half-turn; the final vertex of a request carries last. A zero count emits no
// vertex, and a count above MAX_SEGMENTS is treated as MAX_SEGMENTS. Coordinates are the
// center plus radius times cosine (x) or sine (y), floored by 2^15 and saturated to 16 bits.
// The block works on one request at a time. A request runs as one load beat, fifteen
// steps of the bit-serial divider that splits the span magnitude by the count, then three
// microprogram steps per vertex (sine table read, multiply, add and saturate) and one
// closing step. A request with a zero count takes only its load beat. A stalled output
// holds the emit step. The next request is accepted while the last vertex of the
// previous one still waits in the output register.
module arc_vertex_generator
  import arcvg_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  arcvg_req_if.sink   req,
  arcvg_vtx_if.source vtx
);

  // Count and index width follows the largest count; the table index follows its depth.
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = QUARTER_W + 1 + AW;

  seq_status_t status;
  seq_ctrl_t   ctrl;

  // Request registers.
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;
  logic        [RADIUS_W-1:0] radius;
  logic                       span_neg;
  logic        [CW-1:0]       count;

  // Divider: quo starts as the span magnitude and ends as the quotient.
  logic [SPAN_W-1:0]    quo;
  logic [CW-1:0]        rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CW:0]          div_shift;
  logic                 div_bit;

  // Angle accumulator: magnitude of span*i/count modulo one turn, with its remainder.
  logic [ANGLE_W-1:0] ang_acc;
  logic [CW-1:0]      ang_rem;
  logic [CW:0]        rem_sum;
  logic               rem_wrap;
  logic [CW-1:0]      vidx;

  // Lookup and product stage.
  logic [ANGLE_W-1:0]        phase_sin;
  logic [ANGLE_W-1:0]        phase_cos;
  logic [AW-1:0]             addr_sin;
  logic [AW-1:0]             addr_cos;
  logic [TRIG_W-1:0]         data_sin;
  logic [TRIG_W-1:0]         data_cos;
  logic                      neg_sin;
  logic                      neg_cos;
  logic signed [TRIG_W+1:0]  trig_sin;
  logic signed [TRIG_W+1:0]  trig_cos;
  logic signed [RADIUS_W:0]  radius_s;
  logic signed [RADIUS_W+TRIG_W+2:0] full_x;
  logic signed [RADIUS_W+TRIG_W+2:0] full_y;
  logic signed [30:0]        prod_x;
  logic signed [30:0]        prod_y;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;

  logic out_valid;

  // Folds an angle within one half-turn to its quarter-wave table offset.
  function automatic logic [QUARTER_W:0] fold_quarter(input logic [ANGLE_W-1:0] p);
    logic [QUARTER_W:0] f;
    f = {1'b0, p[QUARTER_W-1:0]};
    return p[QUARTER_W] ? QUARTER_TURN - f : f;
  endfunction

  // Maps a quarter-wave offset of 0 to 2048 onto the table index range.
  function automatic logic [AW-1:0] table_index(input logic [QUARTER_W:0] f);
    logic [PW-1:0] scaled;
    scaled = PW'(f) * PW'(SINE_TABLE_DEPTH);
    return AW'(scaled >> QUARTER_W);
  endfunction

  // Adds the center to the floored product and saturates to 16 bits.
  function automatic logic signed [COORD_W-1:0] place(input logic signed [COORD_W-1:0] c,
                                                       input logic signed [30:0] prod);
    logic signed [COORD_W:0] sum;
    sum = {c[COORD_W-1], c} + {prod[30], prod[30:15]};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return sum[COORD_W-1:0];
  endfunction

  arcvg_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  arcvg_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk      (clk),
    .addr_sin (addr_sin),
    .addr_cos (addr_cos),
    .data_sin (data_sin),
    .data_cos (data_cos)
  );

  // Requests are taken only in the load step of the program.
  assign req.ready = (ctrl.op == OP_LOAD);

  always_comb begin
    // One restoring division step.
    div_shift = {rem, quo[SPAN_W-1]};
    div_bit = (div_shift >= {1'b0, count});
    // The remainder of the accumulated angle stays below twice the count.
    rem_sum = {1'b0, ang_rem} + {1'b0, rem};
    rem_wrap = (rem_sum >= {1'b0, count});
    // The sign of the span is applied to the magnitude before the table lookup.
    phase_sin = span_neg ? ANGLE_W'(0) - ang_acc : ang_acc;
    phase_cos = phase_sin + ANGLE_W'(QUARTER_TURN);
    addr_sin = table_index(fold_quarter(phase_sin));
    addr_cos = table_index(fold_quarter(phase_cos));
    trig_sin = neg_sin ? -$signed({2'b00, data_sin}) : $signed({2'b00, data_sin});
    trig_cos = neg_cos ? -$signed({2'b00, data_cos}) : $signed({2'b00, data_cos});
    radius_s = $signed({1'b0, radius});
    full_x = radius_s * trig_cos;
    full_y = radius_s * trig_sin;
    pos_x = place(cx, prod_x);
    pos_y = place(cy, prod_y);

    status.in_valid = req.valid;
    status.count_zero = (req.segment_count == SEG_W'(0));
    status.div_more = (div_cnt != DIV_CNT_W'(DIV_STEPS - 1));
    status.last_vertex = (vidx == count - CW'(1));
    status.out_free = !out_valid || vtx.ready;
  end

  // Control state: only the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && (ctrl.op == OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (vtx.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath registers: the load step sets up a request, later steps write their own.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          cx <= req.center_x;
          cy <= req.center_y;
          radius <= req.radius;
          span_neg <= req.span[SPAN_W-1];
          quo <= req.span[SPAN_W-1] ? SPAN_W'(-req.span) : SPAN_W'(req.span);
          if (req.segment_count > SEG_W'(MAX_SEGMENTS)) begin
            count <= CW'(MAX_SEGMENTS);
          end else begin
            count <= CW'(req.segment_count);
          end
          rem <= '0;
          div_cnt <= '0;
          ang_acc <= '0;
          ang_rem <= '0;
          vidx <= '0;
        end
        OP_DIV: begin
          quo <= {quo[SPAN_W-2:0], div_bit};
          rem <= div_bit ? CW'(div_shift - {1'b0, count}) : CW'(div_shift);
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        OP_LOOKUP: begin
          neg_sin <= phase_sin[ANGLE_W-1];
          neg_cos <= phase_cos[ANGLE_W-1];
        end
        OP_MUL: begin
          prod_x <= full_x[30:0];
          prod_y <= full_y[30:0];
        end
        OP_EMIT: begin
          vtx.vertex_x <= pos_x;
          vtx.vertex_y <= pos_y;
          vtx.vertex_index <= INDEX_W'(vidx);
          vtx.last <= status.last_vertex;
          vidx <= vidx + CW'(1);
          ang_acc <= ang_acc + quo[ANGLE_W-1:0] + ANGLE_W'(rem_wrap);
          ang_rem <= rem_wrap ? CW'(rem_sum - {1'b0, count}) : CW'(rem_sum);
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign vtx.valid = out_valid;

`ifndef SYNTH
  // A vertex computed in the emit step is presented on the next edge.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && (ctrl.op == OP_EMIT)) |=> vtx.valid)
    else $error("emitted vertex not presented on the output");

  // The angle remainder stays below the count while a request is in work.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op != OP_LOAD) |-> (ang_rem < count))
    else $error("angle remainder reached the segment count");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the arc vertex generator: arc requests in, predicted vertices out.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Build-time choices of the block under test. The predictor below uses the same values.
  localparam int MAX_VERTS = 64;
  localparam int TABLE_DEPTH = 256;

  // Angles are in 1/4096 half-turn units, so 8192 is one full turn and 2048 one quarter.
  localparam int TURN_MASK = 8191;
  localparam int QUARTER = 2048;
  localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;

  // Stimulus shape and run control.
  localparam int RANDOM_ARCS = 430;
  localparam int PAUSE_AT = 200;      // the sender drains the block before this arc
  localparam int HOLD_AFTER = 300;    // vertex beats before the long output stall
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 250;   // longer than one full 64-vertex request

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [arcvg_pkg::COORD_W-1:0] center_x;
    logic signed [arcvg_pkg::COORD_W-1:0] center_y;
    logic        [arcvg_pkg::RADIUS_W-1:0] radius;
    logic signed [arcvg_pkg::SPAN_W-1:0]  span;
    logic        [arcvg_pkg::SEG_W-1:0]   seg_count;
  } arc_req_t;

  typedef struct {
    logic signed [arcvg_pkg::COORD_W-1:0] x;
    logic signed [arcvg_pkg::COORD_W-1:0] y;
    logic        [arcvg_pkg::INDEX_W-1:0] index;
    logic                                 last;
  } vertex_t;

  // Predicts the vertices of every accepted arc and checks the vertex stream against them.
  class arc_vertex_board;
    vertex_t expected_vertices[$];
    int      failures;
    int      sine_q15[TABLE_DEPTH+1];

    // The quarter-wave table: an eleven-term Taylor series in Q2.30, rounded to Q0.15.
    function new();
      u64_t   x;
      u64_t   term;
      longint sum;
      longint q;
      failures = 0;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        x = (RIGHT_ANGLE_Q30 * u64_t'(k)) / u64_t'(TABLE_DEPTH);
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 10; n++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / u64_t'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        q = (sum + 16384) >>> 15;
        if (q > 32767) begin
          q = 32767;
        end
        sine_q15[k] = int'(q);
      end
    endfunction

    function int sine_at(int phase);
      int quad;
      int f;
      int idx;
      int v;
      phase = phase & TURN_MASK;
      quad = phase >> 11;
      f = phase & (QUARTER - 1);
      if ((quad & 1) != 0) begin
        f = QUARTER - f;
      end
      idx = f * TABLE_DEPTH / QUARTER;
      if (idx > TABLE_DEPTH) begin
        idx = TABLE_DEPTH;
      end
      v = sine_q15[idx];
      return ((quad & 2) != 0) ? -v : v;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) begin
        return 16'sh7fff;
      end
      if (v < -32768) begin
        return 16'sh8000;
      end
      return 16'(v);
    endfunction

    function void note_arc(arc_req_t a);
      int      n;
      int      ang;
      int      s;
      int      c;
      longint  r;
      vertex_t v;
      n = (int'(a.seg_count) > MAX_VERTS) ? MAX_VERTS : int'(a.seg_count);
      r = longint'(a.radius);
      for (int i = 0; i < n; i++) begin
        // SystemVerilog integer division truncates toward zero, as the block does.
        ang = (int'(a.span) * i) / n;
        s = sine_at(ang);
        c = sine_at(ang + QUARTER);
        v.x = clamp16(longint'(a.center_x) + ((r * longint'(c)) >>> 15));
        v.y = clamp16(longint'(a.center_y) + ((r * longint'(s)) >>> 15));
        v.index = 6'(i);
        v.last = (i == n - 1);
        expected_vertices.push_back(v);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d index=%0d last=%0d", $time,
                 got.x, got.y, got.index, got.last);
        failures++;
        return;
      end
      want = expected_vertices.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
          got.last !== want.last) begin
        $display("%0t: vertex mismatch: expected x=%0d y=%0d index=%0d last=%0d, got x=%0d y=%0d index=%0d last=%0d",
                 $time, want.x, want.y, want.index, want.last,
                 got.x, got.y, got.index, got.last);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  arcvg_req_if req_ch();
  arcvg_vtx_if vtx_ch();

  arc_vertex_generator #(
    .MAX_SEGMENTS(MAX_VERTS),
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .vtx(vtx_ch)
  );

  arc_vertex_board board;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run (every arc at 64 vertices, every vertex held by the
  // longest receiver stall) stays well under this.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic arc_req_t make_arc(int cx, int cy, int r, int sp, int n);
    arc_req_t a;
    a.center_x = 16'(cx);
    a.center_y = 16'(cy);
    a.radius = 15'(r);
    a.span = 15'(sp);
    a.seg_count = 7'(n);
    return a;
  endfunction

  // Vertex receiver. Each beat it draws a random stall before raising ready, except in calm
  // stretches where ready stays high. Once, after HOLD_AFTER beats, it holds ready low
  // for a long stretch so that the output register and then the request input back up.
  initial begin : vertex_sink
    int  stall;
    int  beats;
    bit  calm;
    bit  held;
    vertex_t got;
    beats = 0;
    calm = 1'b0;
    held = 1'b0;
    vtx_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && beats >= HOLD_AFTER) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 31) == 0) begin
          calm = !calm;
        end
        stall = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        vtx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      vtx_ch.ready <= 1'b1;
      // Signals are read right at the edge, before the block updates them.
      do @(posedge clk); while (!(vtx_ch.valid && vtx_ch.ready));
      got.x = vtx_ch.vertex_x;
      got.y = vtx_ch.vertex_y;
      got.index = vtx_ch.vertex_index;
      got.last = vtx_ch.last;
      board.check_vertex(got);
      beats++;
    end
  end

  // Request sender: reset, a directed set of arcs, then random arcs, then the drain.
  initial begin : arc_source
    arc_req_t plan[$];
    int  gap;
    int  waited;
    int  pick;
    int  cx;
    int  cy;
    int  r;
    int  sp;
    int  n;
    bit  calm;

    board = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.center_x <= '0;
    req_ch.center_y <= '0;
    req_ch.radius <= '0;
    req_ch.span <= '0;
    req_ch.segment_count <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed arcs: zero count, the full circle and the semicircle, saturation at
    // both ends, zero radius, zero span, spans beyond one turn that wrap, counts of
    // one, exactly the maximum and above it, and tiny spans where truncation shows.
    plan.push_back(make_arc(0, 0, 100, 8192, 0));
    plan.push_back(make_arc(32767, -32768, 32767, -16384, 0));
    plan.push_back(make_arc(0, 0, 1600, 8192, 64));
    plan.push_back(make_arc(16, -16, 1600, -4096, 32));
    plan.push_back(make_arc(0, 0, 32767, 8192, 8));
    plan.push_back(make_arc(32767, 32767, 32767, 8192, 16));
    plan.push_back(make_arc(-32768, -32768, 32767, 8192, 16));
    plan.push_back(make_arc(100, 200, 0, 1234, 5));
    plan.push_back(make_arc(-500, 700, 4000, 0, 4));
    plan.push_back(make_arc(0, 0, 20000, 16383, 64));
    plan.push_back(make_arc(0, 0, 20000, -16384, 64));
    plan.push_back(make_arc(1234, -4321, 8000, 8192, 1));
    plan.push_back(make_arc(-100, 100, 8000, 8192, 65));
    plan.push_back(make_arc(300, -300, 12000, -8192, 127));
    plan.push_back(make_arc(0, 0, 32767, -8192, 64));
    plan.push_back(make_arc(10, 20, 30000, 1, 3));
    plan.push_back(make_arc(-10, -20, 30000, -7, 7));
    plan.push_back(make_arc(5, 5, 2048, 4096, 2));
    plan.push_back(make_arc(-32768, 32767, 32767, 2048, 4));
    plan.push_back(make_arc(32767, -32768, 32767, -2048, 4));

    for (int k = 0; k < RANDOM_ARCS; k++) begin
      cx = $urandom;
      cy = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        r = 0;
      end else if (pick == 1) begin
        r = 32767;
      end else begin
        r = $urandom_range(0, 32767);
      end
      // The common spans of real use (full circle, semicircle) take half of the draws, with the rest
      // spread over the whole field, wrapping spans included.
      pick = $urandom_range(0, 5);
      case (pick)
        0: begin
          sp = 8192;
        end
        1: begin
          sp = -4096;
        end
        2: begin
          sp = ($urandom_range(0, 1) == 1) ? -8192 : 4096;
        end
        3: begin
          sp = $urandom;
        end
        default: begin
          sp = $urandom_range(0, 16384) - 8192;
        end
      endcase
      // Mostly short arcs to keep the run quick; some long ones and some above the cap.
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        n = $urandom_range(0, 12);
      end else if (pick < 9) begin
        n = $urandom_range(13, 64);
      end else begin
        n = $urandom_range(65, 127);
      end
      plan.push_back(make_arc(cx, cy, r, sp, n));
    end

    calm = 1'b0;
    foreach (plan[k]) begin
      if ($urandom_range(0, 31) == 0) begin
        calm = !calm;
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (k == PAUSE_AT) begin
        // Let the block run dry before going on.
        req_ch.valid <= 1'b0;
        while (board.expected_vertices.size() > 0) @(posedge clk);
        @(posedge clk);
      end else if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_ch.valid <= 1'b1;
      req_ch.center_x <= plan[k].center_x;
      req_ch.center_y <= plan[k].center_y;
      req_ch.radius <= plan[k].radius;
      req_ch.span <= plan[k].span;
      req_ch.segment_count <= plan[k].seg_count;
      do @(posedge clk); while (!req_ch.ready);
      board.note_arc(plan[k]);
    end
    req_ch.valid <= 1'b0;

    // Wait for the stream to catch up, then a full request time more so that any
    // stray vertex after the last expected one is caught as unexpected.
    waited = 0;
    while (board.expected_vertices.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.expected_vertices.size() > 0) begin
      $display("%0t: %0d expected vertices never arrived, first x=%0d y=%0d index=%0d",
               $time, board.expected_vertices.size(), board.expected_vertices[0].x,
               board.expected_vertices[0].y, board.expected_vertices[0].index);
      board.failures++;
    end

    if (board.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
